@@ rtl/sdc_pkg.sv @@
// Shared types and constants for the SPI-mode SD card sequencer.
// Used by sdc_cfg, sdc_core and sd_spi_card_controller; depends on nothing.
`default_nettype none

package sdc_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [7:0] START_TOKEN  = 8'hFE;
  localparam logic [7:0] R1_IDLE      = 8'h01;
  localparam logic [7:0] R1_READY     = 8'h00;
  localparam logic [7:0] CRC_CMD0     = 8'h95;
  localparam logic [7:0] CRC_CMD8     = 8'h87;
  localparam logic [7:0] CRC_DUMMY    = 8'h01;
  localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41  = 32'h4000_0000;
  localparam logic [15:0] ECHO_EXPECT = 16'h01AA;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_IF   = 6'd8;
  localparam logic [5:0] CMD_READ_BLK  = 6'd17;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_READ = 2'd1,
    OP_BYTE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_IDLE_CLK  = 2'd0,
    REG_POLL_LIM  = 2'd1,
    REG_RETRY_LIM = 2'd2,
    REG_TOKEN_TMO = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_OK     = 4'd0,
    ST_CMD0   = 4'd1,
    ST_CMD8   = 4'd2,
    ST_ECHO   = 4'd3,
    ST_CMD55  = 4'd4,
    ST_ACMD41 = 4'd5,
    ST_CMD58  = 4'd6,
    ST_CMD17  = 4'd7,
    ST_TOKEN  = 4'd8,
    ST_BUSY   = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_IDLECLK,
    PH_CMD,
    PH_R1,
    PH_R7,
    PH_OCR,
    PH_TOKEN,
    PH_DATA,
    PH_CRC,
    PH_TAIL,
    PH_TAIL_OK,
    PH_TAIL_TOKEN
  } phase_t;

  typedef struct packed {
    logic [7:0]  idle_clock_bytes;
    logic [7:0]  response_poll_limit;
    logic [15:0] ready_retry_limit;
    logic [19:0] token_timeout;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       done_res;
    status_t    status;
    logic       card_block_mode;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/sd_spi_card_controller.sv @@
// SPI-mode SD card sequencer: one beat in per SPI byte exchange or request.
// Each beat passes an input register, then a result register, on its way to the output.
// Throughput: one beat per cycle while out_tready is high; state updates in one pass.
// Reset (rst_n low, synchronous): sequencer idle, configuration to defaults, both
// stages empty. Depends on sdc_pkg, sdc_cfg and sdc_core.
`default_nettype none

module sd_spi_card_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // lba[31:0], rx_byte[39:32]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tx_byte[7:0], chip_select[8], data_byte[16:9], done_res[17],
  // status[21:18], card_block_mode[22], zero[23]
  output logic [23:0]      out_tdata,
  output logic [1:0]       out_tuser,  // tx_valid[0], data_valid[1]
  output logic             out_tlast,  // data_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  sdc_pkg::cfg_t cfg;
  sdc_pkg::res_t res, res_r;
  logic          res_valid;
  logic          in_valid_r, out_valid_r;
  logic [39:0]   in_data_r;
  logic [1:0]    in_op_r;
  logic          fire;

  assign cfg_ready = 1'b1;

  sdc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance the held beat when the result register is free or draining
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_op_r   <= in_tuser;
    end
  end

  sdc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .op        (in_op_r),
    .lba       (in_data_r[31:0]),
    .rx_byte   (in_data_r[39:32]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.card_block_mode, res_r.status, res_r.done_res,
                       res_r.data_byte, res_r.chip_select, res_r.tx_byte};
  assign out_tuser  = {res_r.data_valid, res_r.tx_valid};
  assign out_tlast  = res_r.data_last;

endmodule

`default_nettype wire

@@ rtl/sdc_cfg.sv @@
// Configuration register file for the SD card sequencer.
// Depends on sdc_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module sdc_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [1:0]        wr_index,
  input  wire logic [19:0]       wr_data,
  output sdc_pkg::cfg_t          cfg
);

  sdc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_clock_bytes    <= 8'd10;
      cfg_r.response_poll_limit <= 8'd16;
      cfg_r.ready_retry_limit   <= 16'd2000;
      cfg_r.token_timeout       <= 20'd100000;
    end else if (wr_en) begin
      unique case (sdc_pkg::reg_idx_t'(wr_index))
        sdc_pkg::REG_IDLE_CLK:  cfg_r.idle_clock_bytes    <= wr_data[7:0];
        sdc_pkg::REG_POLL_LIM:  cfg_r.response_poll_limit <= wr_data[7:0];
        sdc_pkg::REG_RETRY_LIM: cfg_r.ready_retry_limit   <= wr_data[15:0];
        sdc_pkg::REG_TOKEN_TMO: cfg_r.token_timeout       <= wr_data;
        default:                cfg_r                     <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/sdc_core.sv @@
// Sequencer state and per-byte decision logic of the SD card controller.
// Depends on sdc_pkg; state advances on each fire, result is combinational.
`default_nettype none

module sdc_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic [1:0]    op,
  input  wire logic [31:0]   lba,
  input  wire logic [7:0]    rx_byte,
  input  wire sdc_pkg::cfg_t cfg,
  output logic               res_valid,
  output sdc_pkg::res_t      res
);

  sdc_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  frame_index_r, frame_index_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic [15:0] retry_count_r, retry_count_nxt;
  logic [19:0] wait_count_r, wait_count_nxt;
  logic [7:0]  response_latch_r, response_latch_nxt;
  logic [15:0] echo_bytes_r, echo_bytes_nxt;
  logic        block_addressed_r, block_addressed_nxt;
  logic [47:0] command_frame_r, command_frame_nxt;
  logic        busy_r, busy_nxt;

  // shared decisions
  logic [5:0]  cmd;
  logic [7:0]  idle_lim, poll_lim;
  logic [15:0] retry_lim;
  logic [19:0] token_lim;
  logic [7:0]  poll_inc;
  logic [15:0] retry_inc;
  logic [19:0] wait_inc;
  logic        r1_got, r1_done;
  logic [7:0]  r1_val;
  sdc_pkg::phase_t resp_phase;
  logic        idle_go, tok_hit, tok_expire, data_end;
  logic [2:0]  byte_sel;
  logic        is_byte, is_req;
  logic        start_go, fin_go;
  logic [5:0]  start_cmd;
  logic [31:0] start_arg;
  logic [7:0]  start_crc;
  sdc_pkg::status_t fin_status;

  assign cmd       = command_frame_r[45:40];
  assign idle_lim  = (cfg.idle_clock_bytes == '0) ? 8'd1 : cfg.idle_clock_bytes;
  assign poll_lim  = (cfg.response_poll_limit == '0) ? 8'd1 : cfg.response_poll_limit;
  assign retry_lim = (cfg.ready_retry_limit == '0) ? 16'd1 : cfg.ready_retry_limit;
  assign token_lim = (cfg.token_timeout == '0) ? 20'd1 : cfg.token_timeout;
  assign poll_inc  = poll_count_r + 8'd1;
  assign retry_inc = retry_count_r + 16'd1;
  assign wait_inc  = wait_count_r + 20'd1;
  assign r1_got    = !rx_byte[7];
  assign r1_done   = r1_got || (poll_inc >= poll_lim);
  assign r1_val    = r1_got ? rx_byte : sdc_pkg::IDLE_BYTE;
  assign idle_go   = poll_count_r >= idle_lim;
  assign tok_hit   = rx_byte == sdc_pkg::START_TOKEN;
  assign tok_expire = wait_inc >= token_lim;
  assign data_end  = wait_inc >= 20'(sdc_pkg::SECTOR_BYTES);
  assign byte_sel  = 3'd5 - frame_index_r;
  assign is_byte   = sdc_pkg::op_t'(op) == sdc_pkg::OP_BYTE;
  assign is_req    = (sdc_pkg::op_t'(op) == sdc_pkg::OP_INIT) ||
                     (sdc_pkg::op_t'(op) == sdc_pkg::OP_READ);
  assign res_valid = is_req || (is_byte && busy_r);

  always_comb begin
    if (cmd == sdc_pkg::CMD_SEND_IF && r1_val == sdc_pkg::R1_IDLE)
      resp_phase = sdc_pkg::PH_R7;
    else if (cmd == sdc_pkg::CMD_READ_OCR && r1_val == sdc_pkg::R1_READY)
      resp_phase = sdc_pkg::PH_OCR;
    else if (cmd == sdc_pkg::CMD_READ_BLK && r1_val == sdc_pkg::R1_READY)
      resp_phase = sdc_pkg::PH_TOKEN;
    else
      resp_phase = sdc_pkg::PH_TAIL;
  end

  // Which command to launch or which status to finish with on this beat
  always_comb begin
    start_go   = 1'b0;
    fin_go     = 1'b0;
    start_cmd  = sdc_pkg::CMD_APP;
    start_arg  = '0;
    start_crc  = sdc_pkg::CRC_DUMMY;
    fin_status = sdc_pkg::ST_OK;
    if (!is_byte) begin
      if (sdc_pkg::op_t'(op) == sdc_pkg::OP_READ && !busy_r) begin
        start_go  = 1'b1;
        start_cmd = sdc_pkg::CMD_READ_BLK;
        start_arg = block_addressed_r ? lba : (lba << sdc_pkg::SECTOR_SHIFT);
      end
    end else begin
      unique case (phase_r)
        sdc_pkg::PH_IDLECLK: begin
          if (idle_go) begin
            start_go  = 1'b1;
            start_cmd = sdc_pkg::CMD_GO_IDLE;
            start_crc = sdc_pkg::CRC_CMD0;
          end
        end
        sdc_pkg::PH_CMD, sdc_pkg::PH_R1, sdc_pkg::PH_R7, sdc_pkg::PH_OCR,
        sdc_pkg::PH_TOKEN, sdc_pkg::PH_DATA, sdc_pkg::PH_CRC: begin
          start_go = 1'b0;
        end
        sdc_pkg::PH_TAIL: begin
          unique case (cmd)
            sdc_pkg::CMD_GO_IDLE: begin
              if (response_latch_r == sdc_pkg::R1_IDLE) begin
                start_go  = 1'b1;
                start_cmd = sdc_pkg::CMD_SEND_IF;
                start_arg = sdc_pkg::ARG_CMD8;
                start_crc = sdc_pkg::CRC_CMD8;
              end else begin
                fin_go = 1'b1; fin_status = sdc_pkg::ST_CMD0;
              end
            end
            sdc_pkg::CMD_SEND_IF: begin
              if (response_latch_r != sdc_pkg::R1_IDLE) begin
                fin_go = 1'b1; fin_status = sdc_pkg::ST_CMD8;
              end else if (echo_bytes_r != sdc_pkg::ECHO_EXPECT) begin
                fin_go = 1'b1; fin_status = sdc_pkg::ST_ECHO;
              end else begin
                start_go = 1'b1;
              end
            end
            sdc_pkg::CMD_APP: begin
              if (response_latch_r > sdc_pkg::R1_IDLE) begin
                fin_go = 1'b1; fin_status = sdc_pkg::ST_CMD55;
              end else begin
                start_go  = 1'b1;
                start_cmd = sdc_pkg::CMD_OP_COND;
                start_arg = sdc_pkg::ARG_ACMD41;
              end
            end
            sdc_pkg::CMD_OP_COND: begin
              if (response_latch_r == sdc_pkg::R1_READY) begin
                start_go  = 1'b1;
                start_cmd = sdc_pkg::CMD_READ_OCR;
              end else if (retry_inc >= retry_lim) begin
                fin_go = 1'b1; fin_status = sdc_pkg::ST_ACMD41;
              end else begin
                start_go = 1'b1;
              end
            end
            sdc_pkg::CMD_READ_OCR: begin
              fin_go     = 1'b1;
              fin_status = (response_latch_r == sdc_pkg::R1_READY) ?
                           sdc_pkg::ST_OK : sdc_pkg::ST_CMD58;
            end
            sdc_pkg::CMD_READ_BLK: begin
              fin_go = 1'b1; fin_status = sdc_pkg::ST_CMD17;
            end
            default: begin
              fin_go = 1'b1; fin_status = sdc_pkg::ST_OK;
            end
          endcase
        end
        sdc_pkg::PH_TAIL_TOKEN: begin
          fin_go = 1'b1; fin_status = sdc_pkg::ST_TOKEN;
        end
        default: begin
          fin_go = 1'b1; fin_status = sdc_pkg::ST_OK;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_nxt           = phase_r;
    frame_index_nxt     = frame_index_r;
    poll_count_nxt      = poll_count_r;
    retry_count_nxt     = retry_count_r;
    wait_count_nxt      = wait_count_r;
    response_latch_nxt  = response_latch_r;
    echo_bytes_nxt      = echo_bytes_r;
    block_addressed_nxt = block_addressed_r;
    command_frame_nxt   = command_frame_r;
    busy_nxt            = busy_r;
    if (is_req && !busy_r) begin
      busy_nxt = 1'b1;
      if (sdc_pkg::op_t'(op) == sdc_pkg::OP_INIT) begin
        block_addressed_nxt = 1'b0;
        retry_count_nxt     = '0;
        echo_bytes_nxt      = '0;
        response_latch_nxt  = sdc_pkg::IDLE_BYTE;
        phase_nxt           = sdc_pkg::PH_IDLECLK;
        poll_count_nxt      = 8'd1;
      end
    end else if (is_byte && busy_r) begin
      unique case (phase_r)
        sdc_pkg::PH_IDLECLK: begin
          if (!idle_go) poll_count_nxt = poll_inc;
        end
        sdc_pkg::PH_CMD: begin
          if (frame_index_r < 3'd6) begin
            frame_index_nxt = frame_index_r + 3'd1;
          end else begin
            phase_nxt      = sdc_pkg::PH_R1;
            poll_count_nxt = '0;
          end
        end
        sdc_pkg::PH_R1: begin
          if (!r1_got) poll_count_nxt = poll_inc;
          if (r1_done) begin
            response_latch_nxt = r1_val;
            phase_nxt          = resp_phase;
            if (resp_phase == sdc_pkg::PH_R7 || resp_phase == sdc_pkg::PH_OCR)
              frame_index_nxt = '0;
            if (resp_phase == sdc_pkg::PH_R7) echo_bytes_nxt = '0;
            if (resp_phase == sdc_pkg::PH_TOKEN) wait_count_nxt = '0;
          end
        end
        sdc_pkg::PH_R7, sdc_pkg::PH_OCR: begin
          if (phase_r == sdc_pkg::PH_R7) begin
            if (frame_index_r == 3'd2) echo_bytes_nxt[15:8] = rx_byte;
            if (frame_index_r == 3'd3) echo_bytes_nxt[7:0]  = rx_byte;
          end else if (frame_index_r == 3'd0) begin
            block_addressed_nxt = rx_byte[6];
          end
          if (frame_index_r < 3'd3) frame_index_nxt = frame_index_r + 3'd1;
          else phase_nxt = sdc_pkg::PH_TAIL;
        end
        sdc_pkg::PH_TOKEN: begin
          if (tok_hit) begin
            phase_nxt      = sdc_pkg::PH_DATA;
            wait_count_nxt = '0;
          end else begin
            wait_count_nxt = wait_inc;
            if (tok_expire) phase_nxt = sdc_pkg::PH_TAIL_TOKEN;
          end
        end
        sdc_pkg::PH_DATA: begin
          wait_count_nxt = wait_inc;
          if (data_end) begin
            phase_nxt       = sdc_pkg::PH_CRC;
            frame_index_nxt = '0;
          end
        end
        sdc_pkg::PH_CRC: begin
          if (frame_index_r == 3'd0) frame_index_nxt = 3'd1;
          else phase_nxt = sdc_pkg::PH_TAIL_OK;
        end
        sdc_pkg::PH_TAIL: begin
          if (cmd == sdc_pkg::CMD_OP_COND && response_latch_r != sdc_pkg::R1_READY)
            retry_count_nxt = retry_inc;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    // command launch and finish override the phase handling above
    if (start_go) begin
      command_frame_nxt = {2'b01, start_cmd, start_arg, start_crc};
      frame_index_nxt   = '0;
      phase_nxt         = sdc_pkg::PH_CMD;
      busy_nxt          = 1'b1;
    end
    if (fin_go) begin
      phase_nxt = sdc_pkg::PH_IDLE;
      busy_nxt  = 1'b0;
    end
  end

  // Result fields
  always_comb begin
    res                 = '0;
    res.status          = sdc_pkg::ST_OK;
    res.card_block_mode = block_addressed_nxt;
    if (is_req && busy_r) begin
      res.status = sdc_pkg::ST_BUSY;
    end else if (fin_go) begin
      res.done_res = 1'b1;
      res.status   = fin_status;
    end else begin
      res.tx_valid = 1'b1;
      res.tx_byte  = sdc_pkg::IDLE_BYTE;
      if (start_go || !is_byte) begin
        res.chip_select = start_go;
      end else begin
        unique case (phase_r)
          sdc_pkg::PH_IDLECLK: res.chip_select = 1'b0;
          sdc_pkg::PH_CMD: begin
            res.chip_select = 1'b1;
            if (frame_index_r < 3'd6)
              res.tx_byte = command_frame_r[{byte_sel, 3'b000} +: 8];
          end
          sdc_pkg::PH_R1:
            res.chip_select = !r1_done || (resp_phase != sdc_pkg::PH_TAIL);
          sdc_pkg::PH_R7, sdc_pkg::PH_OCR:
            res.chip_select = frame_index_r < 3'd3;
          sdc_pkg::PH_TOKEN: res.chip_select = tok_hit || !tok_expire;
          sdc_pkg::PH_DATA: begin
            res.chip_select = 1'b1;
            res.data_byte   = rx_byte;
            res.data_valid  = 1'b1;
            res.data_last   = data_end;
          end
          sdc_pkg::PH_CRC: res.chip_select = frame_index_r == 3'd0;
          default:         res.chip_select = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= sdc_pkg::PH_IDLE;
      frame_index_r     <= '0;
      poll_count_r      <= '0;
      retry_count_r     <= '0;
      wait_count_r      <= '0;
      response_latch_r  <= sdc_pkg::IDLE_BYTE;
      echo_bytes_r      <= '0;
      block_addressed_r <= 1'b0;
      command_frame_r   <= '0;
      busy_r            <= 1'b0;
    end else if (fire) begin
      phase_r           <= phase_nxt;
      frame_index_r     <= frame_index_nxt;
      poll_count_r      <= poll_count_nxt;
      retry_count_r     <= retry_count_nxt;
      wait_count_r      <= wait_count_nxt;
      response_latch_r  <= response_latch_nxt;
      echo_bytes_r      <= echo_bytes_nxt;
      block_addressed_r <= block_addressed_nxt;
      command_frame_r   <= command_frame_nxt;
      busy_r            <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking bench for sd_spi_card_controller: plays the SD card over the byte stream,
// predicts every result beat and compares it field by field.
// Depends on sdc_pkg and the sd_spi_card_controller RTL only.
module tb;
  import sdc_pkg::*;

  localparam int ITEMS_TARGET   = 1950;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_AFTER = 400;
  localparam int PRESSURE_HOLD  = 300;

  typedef enum {
    FAULT_NONE, FAULT_CMD0, FAULT_CMD8, FAULT_ECHO, FAULT_APP,
    FAULT_OPCOND, FAULT_OCR, FAULT_READ, FAULT_TOKEN
  } fault_t;

  class sd_seq_scoreboard;
    logic [7:0]  idle_clks   = 8'd10;
    logic [7:0]  poll_limit  = 8'd16;
    logic [15:0] retry_limit = 16'd2000;
    logic [19:0] token_limit = 20'd100000;

    phase_t      phase       = PH_IDLE;
    logic [3:0]  frame_idx   = '0;
    logic [7:0]  poll_count  = '0;
    logic [15:0] retry_count = '0;
    logic [19:0] wait_count  = '0;
    logic [7:0]  r1_latch    = 8'hFF;
    logic [15:0] echo        = '0;
    logic        block_mode  = 1'b0;
    logic [47:0] cmd_frame   = '0;
    logic        busy        = 1'b0;

    res_t pending_results[$];
    res_t cur;
    int   errors, results_seen, beats_in, refusals, finished, finished_ok;
    int   sector_bytes, sectors_read;

    function int unsigned at_least_one(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function void write_reg(reg_idx_t idx, logic [19:0] v);
      case (idx)
        REG_IDLE_CLK:  idle_clks   = v[7:0];
        REG_POLL_LIM:  poll_limit  = v[7:0];
        REG_RETRY_LIM: retry_limit = v[15:0];
        REG_TOKEN_TMO: token_limit = v;
      endcase
    endfunction

    function void send(logic [7:0] b, logic sel);
      cur.tx_byte     = b;
      cur.tx_valid    = 1'b1;
      cur.chip_select = sel;
    endfunction

    function void finish(status_t st);
      cur.tx_valid = 1'b0;
      cur.done_res = 1'b1;
      cur.status   = st;
      phase        = PH_IDLE;
      busy         = 1'b0;
      finished++;
      if (st == ST_OK) finished_ok++;
    endfunction

    function void start_cmd(logic [5:0] cmd, logic [31:0] arg, logic [7:0] crc);
      cmd_frame = {2'b01, cmd, arg, crc};
      frame_idx = '0;
      phase     = PH_CMD;
      send(IDLE_BYTE, 1'b1);
    endfunction

    function void on_response(logic [5:0] cmd);
      if (cmd == CMD_SEND_IF && r1_latch == R1_IDLE) begin
        phase = PH_R7;
        frame_idx = '0;
        echo = '0;
        send(IDLE_BYTE, 1'b1);
      end else if (cmd == CMD_READ_OCR && r1_latch == R1_READY) begin
        phase = PH_OCR;
        frame_idx = '0;
        send(IDLE_BYTE, 1'b1);
      end else if (cmd == CMD_READ_BLK && r1_latch == R1_READY) begin
        phase = PH_TOKEN;
        wait_count = '0;
        send(IDLE_BYTE, 1'b1);
      end else begin
        phase = PH_TAIL;
        send(IDLE_BYTE, 1'b0);
      end
    endfunction

    // Advance the sequencer by one accepted beat; returns 1 when a result is due.
    function bit note_beat(op_t op, logic [31:0] lba, logic [7:0] rx);
      logic [5:0]  cmd;
      logic [47:0] sh;
      if (op == OP_NONE || (op == OP_BYTE && !busy)) return 1'b0;
      cur = '0;
      cmd = cmd_frame[45:40];
      if (op == OP_BYTE) begin
        case (phase)
          PH_IDLECLK: begin
            if (poll_count >= at_least_one(idle_clks)) begin
              start_cmd(CMD_GO_IDLE, 32'h0, CRC_CMD0);
            end else begin
              poll_count++;
              send(IDLE_BYTE, 1'b0);
            end
          end
          PH_CMD: begin
            if (frame_idx < 6) begin
              frame_idx++;
              sh = cmd_frame >> (8 * (6 - frame_idx));
              send(sh[7:0], 1'b1);
            end else begin
              phase = PH_R1;
              poll_count = '0;
              send(IDLE_BYTE, 1'b1);
            end
          end
          PH_R1: begin
            if (!rx[7]) begin
              r1_latch = rx;
              on_response(cmd);
            end else begin
              poll_count++;
              if (poll_count >= at_least_one(poll_limit)) begin
                r1_latch = 8'hFF;
                on_response(cmd);
              end else begin
                send(IDLE_BYTE, 1'b1);
              end
            end
          end
          PH_R7, PH_OCR: begin
            if (phase == PH_R7) begin
              if (frame_idx == 2) echo[15:8] = rx;
              if (frame_idx == 3) echo[7:0] = rx;
            end else if (frame_idx == 0) begin
              block_mode = rx[6];
            end
            if (frame_idx < 3) begin
              frame_idx++;
              send(IDLE_BYTE, 1'b1);
            end else begin
              phase = PH_TAIL;
              send(IDLE_BYTE, 1'b0);
            end
          end
          PH_TOKEN: begin
            if (rx == START_TOKEN) begin
              phase = PH_DATA;
              wait_count = '0;
              send(IDLE_BYTE, 1'b1);
            end else begin
              wait_count++;
              if (wait_count >= at_least_one(token_limit)) begin
                phase = PH_TAIL_TOKEN;
                send(IDLE_BYTE, 1'b0);
              end else begin
                send(IDLE_BYTE, 1'b1);
              end
            end
          end
          PH_DATA: begin
            cur.data_byte  = rx;
            cur.data_valid = 1'b1;
            sector_bytes++;
            wait_count++;
            if (wait_count >= SECTOR_BYTES) begin
              cur.data_last = 1'b1;
              phase = PH_CRC;
              frame_idx = '0;
              sectors_read++;
            end
            send(IDLE_BYTE, 1'b1);
          end
          PH_CRC: begin
            if (frame_idx == 0) begin
              frame_idx = 4'd1;
              send(IDLE_BYTE, 1'b1);
            end else begin
              phase = PH_TAIL_OK;
              send(IDLE_BYTE, 1'b0);
            end
          end
          PH_TAIL: begin
            case (cmd)
              CMD_GO_IDLE: begin
                if (r1_latch == R1_IDLE) start_cmd(CMD_SEND_IF, ARG_CMD8, CRC_CMD8);
                else finish(ST_CMD0);
              end
              CMD_SEND_IF: begin
                if (r1_latch != R1_IDLE) finish(ST_CMD8);
                else if (echo != ECHO_EXPECT) finish(ST_ECHO);
                else start_cmd(CMD_APP, 32'h0, CRC_DUMMY);
              end
              CMD_APP: begin
                if (r1_latch > R1_IDLE) finish(ST_CMD55);
                else start_cmd(CMD_OP_COND, ARG_ACMD41, CRC_DUMMY);
              end
              CMD_OP_COND: begin
                if (r1_latch == R1_READY) begin
                  start_cmd(CMD_READ_OCR, 32'h0, CRC_DUMMY);
                end else begin
                  retry_count++;
                  if (retry_count >= at_least_one(retry_limit)) finish(ST_ACMD41);
                  else start_cmd(CMD_APP, 32'h0, CRC_DUMMY);
                end
              end
              CMD_READ_OCR: begin
                if (r1_latch == R1_READY) finish(ST_OK);
                else finish(ST_CMD58);
              end
              CMD_READ_BLK: finish(ST_CMD17);
              default:      finish(ST_OK);
            endcase
          end
          PH_TAIL_OK:    finish(ST_OK);
          PH_TAIL_TOKEN: finish(ST_TOKEN);
          default:       finish(ST_OK);
        endcase
      end else if (busy) begin
        cur.status = ST_BUSY;
        refusals++;
      end else if (op == OP_INIT) begin
        busy        = 1'b1;
        block_mode  = 1'b0;
        retry_count = '0;
        echo        = '0;
        r1_latch    = 8'hFF;
        phase       = PH_IDLECLK;
        poll_count  = 8'd1;
        send(IDLE_BYTE, 1'b0);
      end else begin
        busy = 1'b1;
        start_cmd(CMD_READ_BLK, block_mode ? lba : lba << SECTOR_SHIFT, CRC_DUMMY);
      end
      cur.card_block_mode = block_mode;
      pending_results.push_back(cur);
      beats_in++;
      return 1'b1;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [23:0] d, logic [1:0] u, logic l);
      res_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: tdata %h", d);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("tx_byte",         want.tx_byte,         d[7:0]);
      check_field("tx_valid",        want.tx_valid,        u[0]);
      check_field("chip_select",     want.chip_select,     d[8]);
      check_field("data_byte",       want.data_byte,       d[16:9]);
      check_field("data_valid",      want.data_valid,      u[1]);
      check_field("data_last",       want.data_last,       l);
      check_field("done_res",        want.done_res,        d[17]);
      check_field("status",          want.status,          d[21:18]);
      check_field("card_block_mode", want.card_block_mode, d[22]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // lba[31:0], rx_byte[39:32]
  logic [1:0]  in_tuser;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // tx_byte, chip_select, data_byte, done_res, status, block mode
  logic [1:0]  out_tuser;  // tx_valid[0], data_valid[1]
  logic        out_tlast;  // data_last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  sd_seq_scoreboard sb = new();

  fault_t      plan_fault;
  bit          plan_silent;
  int unsigned plan_busy_rounds;
  int unsigned plan_token_wait;
  bit          steady;
  bit          pressure_done;
  int          items_done;
  int          quiet_cycles;
  int          settings_used;

  sd_spi_card_controller u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_lba();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] r1_reply(bit bad, logic [7:0] good, int bad_floor);
    logic [7:0] v;
    if (!bad) return good;
    if (plan_silent) return 8'h80 | 8'($urandom_range(0, 127));
    v = 8'($urandom_range(bad_floor, 127));
    if (v == good) v = 8'h7F;
    return v;
  endfunction

  // Card side: pick the byte the card returns for the transfer just requested.
  function automatic logic [7:0] card_reply();
    logic [5:0] cmd;
    logic [7:0] v;
    cmd = sb.cmd_frame[45:40];
    v = 8'($urandom_range(0, 255));
    case (sb.phase)
      PH_R1: begin
        if (sb.poll_count + 1 < sb.at_least_one(sb.poll_limit) && $urandom_range(0, 3) == 0)
          v = 8'h80 | 8'($urandom_range(0, 127));
        else begin
          case (cmd)
            CMD_GO_IDLE:  v = r1_reply(plan_fault == FAULT_CMD0, R1_IDLE, 0);
            CMD_SEND_IF:  v = r1_reply(plan_fault == FAULT_CMD8, R1_IDLE, 0);
            CMD_APP:      v = r1_reply(plan_fault == FAULT_APP, 8'($urandom_range(0, 1)), 2);
            CMD_OP_COND: begin
              if (plan_fault == FAULT_OPCOND || sb.retry_count < plan_busy_rounds)
                v = plan_silent ? 8'h80 | 8'($urandom_range(0, 127)) : R1_IDLE;
              else
                v = R1_READY;
            end
            CMD_READ_OCR: v = r1_reply(plan_fault == FAULT_OCR, R1_READY, 0);
            default:      v = r1_reply(plan_fault == FAULT_READ, R1_READY, 0);
          endcase
        end
      end
      PH_R7: begin
        if (sb.frame_idx == 2) v = ECHO_EXPECT[15:8];
        if (sb.frame_idx == 3)
          v = (plan_fault == FAULT_ECHO) ? ECHO_EXPECT[7:0] ^ 8'($urandom_range(1, 255))
                                         : ECHO_EXPECT[7:0];
      end
      PH_TOKEN: begin
        if (plan_fault == FAULT_TOKEN ||
            (sb.wait_count < plan_token_wait &&
             sb.wait_count + 1 < sb.at_least_one(sb.token_limit))) begin
          if (v == START_TOKEN) v = IDLE_BYTE;
        end else begin
          v = START_TOKEN;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic op_t stray_op();
    case ($urandom_range(0, 2))
      0:       return OP_NONE;
      1:       return OP_INIT;
      default: return OP_READ;
    endcase
  endfunction

  // Entered and left at a falling edge.
  task automatic push_item(op_t op, logic [31:0] lba, logic [7:0] rx);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {rx, lba};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sb.note_beat(op, lba, rx)) items_done++;
    @(negedge clk);
  endtask

  task automatic pump(int noise_pct);
    while (sb.busy) begin
      if ($urandom_range(0, 99) < noise_pct) push_item(stray_op(), $urandom, 8'h00);
      push_item(OP_BYTE, $urandom, card_reply());
    end
  endtask

  task automatic run_sequence(op_t start_op, logic [31:0] lba, int noise_pct);
    steady = ($urandom_range(0, 3) == 0);
    push_item(start_op, lba, 8'($urandom_range(0, 255)));
    pump(noise_pct);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [19:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain every outstanding result, then let the two pipeline stages empty.
  task automatic quiesce();
    in_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result sink with random back-pressure and one long hold-off.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!pressure_done && sb.results_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        out_tready = 1'b0;
        repeat (PRESSURE_HOLD) @(negedge clk);
      end
      stall = gap_len();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int          r;
    int unsigned lim;
    logic [19:0] v_idle, v_poll, v_retry, v_token;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_NONE;
    cfg_valid = 1'b0;
    cfg_index = REG_IDLE_CLK;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: ignored beats, read before init with busy refusals, silent CMD0.
    write_reg(REG_IDLE_CLK, 20'd1);
    write_reg(REG_POLL_LIM, 20'd1);
    steady      = 1'b1;
    plan_fault  = FAULT_READ;
    plan_silent = 1'b0;
    push_item(OP_NONE, 32'hFFFF_FFFF, 8'hFF);
    push_item(OP_BYTE, 32'h0, 8'h00);
    push_item(OP_READ, 32'hFFFF_FFFF, 8'h00);
    push_item(OP_INIT, 32'h0, 8'hFF);
    push_item(OP_READ, 32'h8000_0001, 8'hFF);
    pump(0);
    plan_fault  = FAULT_CMD0;
    plan_silent = 1'b1;
    run_sequence(OP_INIT, 32'h0, 0);

    // Random: defaults, maxima, zeros, ones, then small random settings.
    while (items_done < ITEMS_TARGET) begin
      quiesce();
      case (settings_used)
        0: begin v_idle = 20'd10;  v_poll = 20'd16;  v_retry = 20'd2000;  v_token = 20'd100000; end
        1: begin v_idle = 20'd255; v_poll = 20'd255; v_retry = 20'd65535; v_token = 20'hFFFFF; end
        2: begin v_idle = 20'd0;   v_poll = 20'd0;   v_retry = 20'd0;     v_token = 20'd0; end
        3: begin v_idle = 20'd1;   v_poll = 20'd1;   v_retry = 20'd1;     v_token = 20'd1; end
        default: begin
          v_idle  = $urandom_range(1, 30);
          v_poll  = $urandom_range(1, 40);
          v_retry = $urandom_range(1, 12);
          v_token = $urandom_range(1, 60);
        end
      endcase
      write_reg(REG_IDLE_CLK, v_idle);
      write_reg(REG_POLL_LIM, v_poll);
      write_reg(REG_RETRY_LIM, v_retry);
      write_reg(REG_TOKEN_TMO, v_token);
      settings_used++;
      repeat ($urandom_range(3, 7)) begin
        if (items_done >= ITEMS_TARGET) break;
        if ($urandom_range(0, 4) == 0)
          push_item($urandom_range(0, 1) ? OP_NONE : OP_BYTE, $urandom, 8'($urandom));
        plan_silent = ($urandom_range(0, 3) == 0);
        plan_token_wait = $urandom_range(0, 6);
        if ($urandom_range(0, 99) < 55) begin
          lim = sb.at_least_one(sb.retry_limit);
          plan_busy_rounds = $urandom_range(0, lim > 3 ? 3 : lim - 1);
          r = $urandom_range(0, 99);
          if (r < 62)      plan_fault = FAULT_NONE;
          else if (r < 68) plan_fault = FAULT_CMD0;
          else if (r < 74) plan_fault = FAULT_CMD8;
          else if (r < 80) plan_fault = FAULT_ECHO;
          else if (r < 86) plan_fault = FAULT_APP;
          else if (r < 93) plan_fault = (lim <= 8) ? FAULT_OPCOND : FAULT_NONE;
          else             plan_fault = FAULT_OCR;
          run_sequence(OP_INIT, pick_lba(), 3);
        end else begin
          // Keep full sector reads rare: each one costs over 500 beats.
          if (sb.sectors_read == 0 || $urandom_range(0, 99) < 8)
            plan_fault = FAULT_NONE;
          else if ($urandom_range(0, 1) && sb.at_least_one(sb.token_limit) <= 40)
            plan_fault = FAULT_TOKEN;
          else
            plan_fault = FAULT_READ;
          run_sequence(OP_READ, pick_lba(), 3);
        end
      end
    end
    quiesce();
    repeat (6) @(posedge clk);

    $display("run covered %0d counted beats in, %0d result beats, %0d busy refusals, %0d settings",
             sb.beats_in, sb.results_seen, sb.refusals, settings_used);
    $display("sequences ended: %0d (%0d clean), sector bytes: %0d over %0d full reads",
             sb.finished, sb.finished_ok, sb.sector_bytes, sb.sectors_read);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sd_spi_card_controller.f @@
rtl/sdc_pkg.sv
rtl/sdc_cfg.sv
rtl/sdc_core.sv
rtl/sd_spi_card_controller.sv
verif/tb.sv
